[rtl/core/bdec_pkg.sv]
package bdec_pkg;

    // event codes on the result channel
    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_LEFT        = 3'd1,
        EV_RIGHT       = 3'd2,
        EV_CENTER      = 3'd3,
        EV_LONG_CENTER = 3'd4
    } event_t;

    // button bit positions and single-button masks
    localparam int unsigned BTN_CENTER_BIT = 2;
    localparam logic [2:0]  BTN_LEFT       = 3'b001;
    localparam logic [2:0]  BTN_RIGHT      = 3'b010;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W        = 8;
    localparam logic [7:0]  CFG_DEBOUNCE     = 8'd0;
    localparam logic [7:0]  CFG_REPEAT_GUARD = 8'd1;
    localparam logic [7:0]  CFG_CENTER_GUARD = 8'd2;
    localparam logic [7:0]  CFG_LONG_PRESS   = 8'd3;

    // configuration reset values, milliseconds
    localparam logic [15:0] RST_DEBOUNCE     = 16'd25;
    localparam logic [15:0] RST_REPEAT_GUARD = 16'd60;
    localparam logic [15:0] RST_CENTER_GUARD = 16'd250;
    localparam logic [15:0] RST_LONG_PRESS   = 16'd900;

endpackage

[rtl/core/button_debounce_event_decoder.sv]
// An item goes from the input register to the result register, which drives out_valid.
// Throughput: one item per cycle if not stalled; decode state updates in the same cycle as
// the result register, so consecutive samples see each other's effect without a gap.
// Reset (rst_n low, asynchronous): all decode state cleared to zero, both channels empty,
// timing registers back to debounce 25, repeat guard 60, center guard 250, long press 900.
module button_debounce_event_decoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    // sample channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     buttons_down,
    input  logic [31:0]                    time_ms,
    // event channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     event_res,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bdec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);

    // configuration registers
    logic [15:0] debounce_reg;
    logic [15:0] repeat_guard_reg;
    logic [15:0] center_guard_reg;
    logic [15:0] long_press_reg;

    // input stage
    logic        in_vld_reg;
    logic [2:0]  raw_reg;
    logic [31:0] now_reg;

    // decode state
    logic [2:0]  prev_raw_reg,     prev_raw_next;
    logic [31:0] raw_change_reg,   raw_change_next;
    logic [2:0]  steady_reg,       steady_next;
    logic        press_reg,        press_next;
    logic        long_sent_reg,    long_sent_next;
    logic [2:0]  held_reg,         held_next;
    logic [31:0] press_begin_reg,  press_begin_next;
    logic [31:0] last_event_reg,   last_event_next;

    // result stage
    logic        out_vld_reg;
    logic [2:0]  event_reg;

    logic              advance;
    bdec_pkg::event_t  ev;
    logic [31:0]       since_change;
    logic [31:0]       since_last;
    logic [31:0]       since_press;
    logic [15:0]       guard;

    // input item moves on when the result register is free or being drained
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign event_res = event_reg;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= bdec_pkg::RST_DEBOUNCE;
            repeat_guard_reg <= bdec_pkg::RST_REPEAT_GUARD;
            center_guard_reg <= bdec_pkg::RST_CENTER_GUARD;
            long_press_reg   <= bdec_pkg::RST_LONG_PRESS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bdec_pkg::CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                bdec_pkg::CFG_REPEAT_GUARD: repeat_guard_reg <= cfg_data;
                bdec_pkg::CFG_CENTER_GUARD: center_guard_reg <= cfg_data;
                bdec_pkg::CFG_LONG_PRESS:   long_press_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            raw_reg <= buttons_down;
            now_reg <= time_ms;
        end
    end

    // wrapping elapsed times
    assign since_change = now_reg - raw_change_reg;
    assign since_last   = now_reg - last_event_reg;
    assign since_press  = now_reg - press_begin_reg;
    assign guard        = held_reg[bdec_pkg::BTN_CENTER_BIT] ? center_guard_reg
                                                             : repeat_guard_reg;

    // debounce and event decode
    always_comb
    begin
        prev_raw_next    = prev_raw_reg;
        raw_change_next  = raw_change_reg;
        steady_next      = steady_reg;
        press_next       = press_reg;
        long_sent_next   = long_sent_reg;
        held_next        = held_reg;
        press_begin_next = press_begin_reg;
        last_event_next  = last_event_reg;
        ev               = bdec_pkg::EV_NONE;
        if (advance)
        begin
            if (raw_reg != prev_raw_reg)
            begin
                // raw change restarts the debounce timer
                prev_raw_next   = raw_reg;
                raw_change_next = now_reg;
            end
            else if (since_change < {16'd0, debounce_reg})
            begin
                // still settling
            end
            else if (raw_reg != steady_reg)
            begin
                steady_next = raw_reg;
                if (raw_reg != 3'd0 && !press_reg)
                begin
                    // press starts
                    press_next       = 1'b1;
                    long_sent_next   = 1'b0;
                    held_next        = raw_reg;
                    press_begin_next = now_reg;
                end
                else if (raw_reg == 3'd0 && press_reg)
                begin
                    // release, emit unless in guard, long press sent or held is left+right
                    press_next = 1'b0;
                    if (!(since_last < {16'd0, guard}) && !long_sent_reg)
                    begin
                        last_event_next = now_reg;
                        if (held_reg[bdec_pkg::BTN_CENTER_BIT])
                        begin
                            ev = bdec_pkg::EV_CENTER;
                        end
                        else if (held_reg == bdec_pkg::BTN_LEFT)
                        begin
                            ev = bdec_pkg::EV_LEFT;
                        end
                        else if (held_reg == bdec_pkg::BTN_RIGHT)
                        begin
                            ev = bdec_pkg::EV_RIGHT;
                        end
                    end
                end
            end
            else if (press_reg && !long_sent_reg && steady_reg[bdec_pkg::BTN_CENTER_BIT]
                     && since_press >= {16'd0, long_press_reg})
            begin
                // long center hold, once per press
                long_sent_next  = 1'b1;
                last_event_next = now_reg;
                ev              = bdec_pkg::EV_LONG_CENTER;
            end
        end
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= 3'd0;
            raw_change_reg  <= 32'd0;
            steady_reg      <= 3'd0;
            press_reg       <= 1'b0;
            long_sent_reg   <= 1'b0;
            held_reg        <= 3'd0;
            press_begin_reg <= 32'd0;
            last_event_reg  <= 32'd0;
        end
        else
        begin
            prev_raw_reg    <= prev_raw_next;
            raw_change_reg  <= raw_change_next;
            steady_reg      <= steady_next;
            press_reg       <= press_next;
            long_sent_reg   <= long_sent_next;
            held_reg        <= held_next;
            press_begin_reg <= press_begin_next;
            last_event_reg  <= last_event_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg <= ev;
        end
    end

endmodule
